[rtl/mdpf_pkg.sv]
package mdpf_pkg;

    // Fixed field widths of the stream items.
    localparam int COORD_BITS = 16;
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SQ_W       = 34;
    localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

    // Distance arithmetic widths.
    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SUM_EXT_W = (SUM_W > SQ_W) ? SUM_W : SQ_W + 1;

    // Stream payload widths.
    localparam int PT_W      = 3 * COORD_BITS;
    localparam int S_DATA_W  = ((PT_W + 7) / 8) * 8;
    localparam int RES_W     = 2 + IDX_W + CNT_W + SQ_W + 2 * IDX_W;
    localparam int M_DATA_W  = ((RES_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic REG_MIN_DIST_SQ = 1'b0;
    localparam logic [SQ_W-1:0] MIN_DIST_SQ_RESET = SQ_W'(571536);

    typedef struct packed {
        logic load;      // take the input beat into the candidate register
        logic scan_run;  // issue store reads while any remain
        logic commit;    // write back the verdict and the result beat
    } t_cmd;

    typedef struct packed {
        logic full;       // store holds MAX_POINTS entries
        logic scan_done;  // all reads issued and the compare pipe drained
        logic out_free;   // output register can take a result this cycle
    } t_status;

endpackage

[rtl/min_distance_point_filter.sv]
// Minimum-distance point filter. Each input beat offers one 3-D candidate point;
// it is kept only if its squared distance to every stored point is at least
// min_dist_sq (APB register 0, byte address 0, reset 571536) and a slot is free.
// One result beat follows every input beat with the verdict, the slot used, the
// stored count and the closest stored pair seen so far (ties keep the older pair).
// Setting the tuser flag empties the store and the closest pair before the test.
// Items are handled one at a time. The result beat is presented only after
// every stored point has been compared, because the single-port point store
// delivers one stored point per cycle into a three-stage distance and compare
// pipeline that must drain before the verdict is known. With the store full no
// point is read, the candidate is rejected and store_full is set. The commit
// waits while the output register still holds a result that the downstream
// side has not taken. The next input beat is taken as soon as the result sits
// in the output register, even if the downstream side has not yet taken it.
// Write the register only while idle.
module min_distance_point_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Candidate stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_coord [15:0], y_coord [31:16], z_coord [47:32]
    input  logic [mdpf_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // clear_store [0]
    input  logic                               s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accepted [0], store_full [1], point_index [11:2], point_count [22:12],
    // closest_sq [56:23], pair_first [66:57], pair_second [76:67], zero [79:77]
    output logic [mdpf_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mdpf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mdpf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mdpf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import mdpf_pkg::*;

    logic [SQ_W-1:0] r_min_dist_sq;
    logic            reg_sel;
    t_cmd            cmd;
    t_status         status;

    // Registers sit on 8-byte boundaries, so the index is the address above bit 2.
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_MIN_DIST_SQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist_sq <= MIN_DIST_SQ_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_min_dist_sq <= pwdata[SQ_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? APB_DATA_W'(r_min_dist_sq) : '0;

    // The controller sequences load, scan and commit; the datapath owns the
    // store, the distance pipeline, the closest pair and the output register.
    mdpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mdpf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_min_dist_sq (r_min_dist_sq),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata)
    );

endmodule

[rtl/mdpf_ctrl.sv]
module mdpf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  mdpf_pkg::t_status i_status,
    output mdpf_pkg::t_cmd    o_cmd
);
    import mdpf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.full || i_status.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready     = (r_state == S_IDLE);
    assign o_cmd.load     = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.scan_run = (r_state == S_SCAN) && !i_status.full;
    assign o_cmd.commit   = (r_state == S_FINISH) && i_status.out_free;

endmodule

[rtl/mdpf_datapath.sv]
module mdpf_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mdpf_pkg::t_cmd                     i_cmd,
    output mdpf_pkg::t_status                  o_status,
    input  logic [mdpf_pkg::S_DATA_W-1:0]      i_s_tdata,
    input  logic                               i_s_tuser,
    input  logic [mdpf_pkg::SQ_W-1:0]          i_min_dist_sq,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [mdpf_pkg::M_DATA_W-1:0]      o_m_tdata
);
    import mdpf_pkg::*;

    // Point store, one read or one write per cycle, registered read data.
    logic [PT_W-1:0] r_mem [MAX_POINTS];
    logic [PT_W-1:0] r_rd_data;

    logic [PT_W-1:0]  r_cand;
    logic [CNT_W-1:0] r_count;
    logic [SQ_W-1:0]  r_best_sq;
    logic [IDX_W-1:0] r_best_first;
    logic [IDX_W-1:0] r_best_second;

    logic [CNT_W-1:0] r_rd_idx;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic [IDX_W-1:0] r_idx1;
    logic [IDX_W-1:0] r_idx2;
    logic [IDX_W-1:0] r_idx3;
    logic [PROD_W-1:0] r_sq [3];
    logic [SQ_W-1:0]  r_dist;

    logic             r_close;
    logic [SQ_W-1:0]  r_cmin;
    logic [IDX_W-1:0] r_cidx;

    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic rd_en;
    logic full;
    logic signed [DIFF_W-1:0] diff [3];
    logic signed [PROD_W-1:0] prod [3];
    logic [SUM_W-1:0]     sum;
    logic [SUM_EXT_W-1:0] sum_ext;
    logic [SQ_W-1:0]      sum_sat;

    logic             accept;
    logic             improve;
    logic [IDX_W-1:0] n_point_index;
    logic [CNT_W-1:0] n_count;
    logic [SQ_W-1:0]  n_best_sq;
    logic [IDX_W-1:0] n_best_first;
    logic [IDX_W-1:0] n_best_second;

    assign full  = (r_count == CNT_W'(MAX_POINTS));
    assign rd_en = i_cmd.scan_run && (r_rd_idx < r_count);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
        end
        if (i_cmd.commit && accept) begin
            r_mem[r_count[IDX_W-1:0]] <= r_cand;
        end
    end

    // Stage 1: per-axis differences and squares.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = DIFF_W'($signed(r_cand[k*COORD_BITS +: COORD_BITS]))
                    - DIFF_W'($signed(r_rd_data[k*COORD_BITS +: COORD_BITS]));
            prod[k] = PROD_W'(diff[k]) * PROD_W'(diff[k]);
        end
    end

    // Stage 2: sum of squares, saturated to the result width.
    assign sum     = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    assign sum_ext = SUM_EXT_W'(sum);
    assign sum_sat = (sum_ext > SUM_EXT_W'(SQ_MAX)) ? SQ_MAX : sum_ext[SQ_W-1:0];

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_rd_idx[IDX_W-1:0];
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= $unsigned(prod[k]);
        end
        r_dist <= sum_sat;
        if (i_cmd.load) begin
            r_cand <= i_s_tdata[PT_W-1:0];
        end
    end

    // Commit arithmetic.
    assign accept        = !full && !r_close;
    assign improve       = accept && (r_cmin < r_best_sq);
    assign n_point_index = accept ? r_count[IDX_W-1:0] : '0;
    assign n_count       = accept ? r_count + CNT_W'(1) : r_count;
    assign n_best_sq     = improve ? r_cmin : r_best_sq;
    assign n_best_first  = improve ? r_cidx : r_best_first;
    assign n_best_second = improve ? r_count[IDX_W-1:0] : r_best_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_best_sq     <= SQ_MAX;
            r_best_first  <= '0;
            r_best_second <= '0;
            r_rd_idx      <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_close       <= 1'b0;
            r_cmin        <= SQ_MAX;
            r_cidx        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            // Stage 3: spacing test and nearest stored neighbor of the candidate.
            if (r_v3) begin
                if (r_dist < i_min_dist_sq) begin
                    r_close <= 1'b1;
                end
                if (r_dist < r_cmin) begin
                    r_cmin <= r_dist;
                    r_cidx <= r_idx3;
                end
            end
            if (i_cmd.load) begin
                r_rd_idx <= '0;
                r_close  <= 1'b0;
                r_cmin   <= SQ_MAX;
                r_cidx   <= '0;
                if (i_s_tuser) begin
                    r_count       <= '0;
                    r_best_sq     <= SQ_MAX;
                    r_best_first  <= '0;
                    r_best_second <= '0;
                end
            end
            if (i_cmd.commit) begin
                r_count       <= n_count;
                r_best_sq     <= n_best_sq;
                r_best_first  <= n_best_first;
                r_best_second <= n_best_second;
                r_out_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= M_DATA_W'({n_best_second, n_best_first, n_best_sq, n_count,
                                     n_point_index, full, accept});
        end
    end

    assign o_status.full      = full;
    assign o_status.scan_done = (r_rd_idx >= r_count) && !r_v1 && !r_v2 && !r_v3;
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("stored point count exceeds the store depth");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed result not presented on the output");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_sq != SQ_MAX) |-> (r_best_first < r_best_second))
        else $error("closest pair indices out of order");

    a_no_read_past_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd_idx < r_count) && !full)
        else $error("store read beyond the filled slots");
`endif

endmodule

[tb/sv/min_distance_point_filter_tb.sv]
module min_distance_point_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdpf_pkg::*;

    // A 2 ns clock. Reset is held at the start and is never asserted again.
    localparam int RESET_CYCLES  = 11;
    // A candidate takes longer the more points are stored, plus the stalls.
    // Every run starts with a cleared store, so the store stays small and the
    // watchdog sits far above any correct run.
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 70;

    localparam logic [APB_ADDR_W-1:0] THRESH_ADDR = APB_ADDR_W'(8 * REG_MIN_DIST_SQ);

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // Bit offsets of the result fields in m_axis_tdata, lowest field first.
    localparam int ACC_LO    = 0;
    localparam int FULL_LO   = 1;
    localparam int IDX_LO    = 2;
    localparam int CNT_LO    = IDX_LO + IDX_W;
    localparam int SQ_LO     = CNT_LO + CNT_W;
    localparam int FIRST_LO  = SQ_LO + SQ_W;
    localparam int SECOND_LO = FIRST_LO + IDX_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

    typedef struct packed {
        logic            accepted;
        logic            store_full;
        logic [IDX_W-1:0] point_index;
        logic [CNT_W-1:0] point_count;
        logic [SQ_W-1:0]  closest_sq;
        logic [IDX_W-1:0] pair_first;
        logic [IDX_W-1:0] pair_second;
    } t_verdict;

    // One candidate beat. When known is set, the verdict typed in beside it
    // is the expectation; otherwise the predictor supplies it.
    typedef struct packed {
        t_point   pt;
        logic     clr;
        logic     known;
        t_verdict verdict;
    } t_cand;

    // Directed rows may first retune the threshold, once the block is idle.
    typedef struct packed {
        logic            cfg_write;
        logic [SQ_W-1:0] cfg_value;
        t_cand           cand;
    } t_table_row;

    typedef enum {CLUSTER, EDGES, ANYWHERE} t_spot_mode;

    localparam t_verdict PREDICTED = '0;

    // Directed stimulus. Rows with a typed verdict are the ones whose outcome
    // is obvious: the first point after reset, the exact-threshold boundary,
    // ties, clears, and the two threshold extremes.
    localparam t_table_row DIRECTED_ROWS [20] = '{
        // Reset threshold 571536 = 756^2. First point lands in slot 0.
        '{1'b0, '0, '{'{16'sd0, 16'sd0, 16'sd0}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd0, 11'd1, SQ_MAX, 10'd0, 10'd0}}},
        // Exactly at the threshold: not strictly closer, so it is kept.
        '{1'b0, '0, '{'{16'sd0, 16'sd0, 16'sd756}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd1, 11'd2, 34'd571536, 10'd0, 10'd1}}},
        // One unit inside the threshold: rejected, pair unchanged.
        '{1'b0, '0, '{'{16'sd0, 16'sd0, 16'sd755}, 1'b0,
            1'b1, '{1'b0, 1'b0, 10'd0, 11'd2, 34'd571536, 10'd0, 10'd1}}},
        // Coordinate extremes, far from everything.
        '{1'b0, '0, '{'{COORD_MAX, COORD_MAX, COORD_MAX}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd2, 11'd3, 34'd571536, 10'd0, 10'd1}}},
        '{1'b0, '0, '{'{COORD_MIN, COORD_MIN, COORD_MIN}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd3, 11'd4, 34'd571536, 10'd0, 10'd1}}},
        '{1'b0, '0, '{'{COORD_MIN, COORD_MAX, COORD_MIN}, 1'b0, 1'b0, PREDICTED}},
        '{1'b0, '0, '{'{COORD_MAX, COORD_MIN, 16'sd0}, 1'b0, 1'b0, PREDICTED}},
        // Clearing empties the store before the candidate is tested.
        '{1'b0, '0, '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1,
            1'b1, '{1'b1, 1'b0, 10'd0, 11'd1, SQ_MAX, 10'd0, 10'd0}}},
        '{1'b0, '0, '{'{16'sd1000, 16'sd0, 16'sd0}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd1, 11'd2, 34'd1000000, 10'd0, 10'd1}}},
        // Tie with the held closest distance: the older pair stays.
        '{1'b0, '0, '{'{-16'sd1000, 16'sd0, 16'sd0}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd2, 11'd3, 34'd1000000, 10'd0, 10'd1}}},
        '{1'b0, '0, '{'{16'sd0, 16'sd1000, 16'sd0}, 1'b0, 1'b0, PREDICTED}},
        '{1'b0, '0, '{'{16'sd500, 16'sd800, 16'sd0}, 1'b0, 1'b0, PREDICTED}},
        '{1'b0, '0, '{'{16'sd1800, 16'sd0, 16'sd0}, 1'b0, 1'b0, PREDICTED}},
        // Threshold zero: even identical points are kept, distance zero wins.
        '{1'b1, '0, '{'{16'sd5, 16'sd5, 16'sd5}, 1'b1,
            1'b1, '{1'b1, 1'b0, 10'd0, 11'd1, SQ_MAX, 10'd0, 10'd0}}},
        '{1'b0, '0, '{'{16'sd5, 16'sd5, 16'sd5}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd1, 11'd2, 34'd0, 10'd0, 10'd1}}},
        '{1'b0, '0, '{'{16'sd5, 16'sd5, 16'sd5}, 1'b0,
            1'b1, '{1'b1, 1'b0, 10'd2, 11'd3, 34'd0, 10'd0, 10'd1}}},
        // Largest threshold: only the first point of a cleared store survives.
        '{1'b1, SQ_MAX, '{'{COORD_MIN, COORD_MIN, COORD_MIN}, 1'b1,
            1'b1, '{1'b1, 1'b0, 10'd0, 11'd1, SQ_MAX, 10'd0, 10'd0}}},
        '{1'b0, '0, '{'{COORD_MAX, COORD_MAX, COORD_MAX}, 1'b0,
            1'b1, '{1'b0, 1'b0, 10'd0, 11'd1, SQ_MAX, 10'd0, 10'd0}}},
        '{1'b0, '0, '{'{16'sd0, 16'sd0, 16'sd0}, 1'b0,
            1'b1, '{1'b0, 1'b0, 10'd0, 11'd1, SQ_MAX, 10'd0, 10'd0}}},
        '{1'b0, '0, '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1,
            1'b1, '{1'b1, 1'b0, 10'd0, 11'd1, SQ_MAX, 10'd0, 10'd0}}}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: its own copy of the point store, the closest pair and
    // the threshold register.
    t_point          kept_pts [MAX_POINTS];
    int              kept_count = 0;
    logic [SQ_W-1:0] best_sq    = SQ_MAX;
    int              best_lo    = 0;
    int              best_hi    = 0;
    logic [SQ_W-1:0] spacing_sq = MIN_DIST_SQ_RESET;

    t_cand    cand_q [$];             // beats waiting to be offered
    t_verdict expected_verdicts [$];  // one per candidate taken, oldest first

    // Traffic shaping, set per phase by the sequencer.
    int gap_pct      = 20;
    int stall_pct    = 20;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    int       fail_count  = 0;
    int       cycle_count = 0;
    int       send_gap    = 0;
    int       stall_left  = 0;
    int       hold_left   = 0;
    t_cand    on_wire;
    t_verdict tx_want;
    t_verdict rx_got;
    t_verdict rx_want;

    min_distance_point_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Squared Euclidean distance, saturated to the result width. With 16-bit
    // coordinates the sum never reaches saturation, but the clamp is kept so
    // the predictor matches the block for any coordinate width.
    function automatic logic [SQ_W-1:0] sq_distance(t_point a, t_point b);
        longint dx;
        longint dy;
        longint dz;
        longint sum;
        dx  = longint'($signed(a.x)) - longint'($signed(b.x));
        dy  = longint'($signed(a.y)) - longint'($signed(b.y));
        dz  = longint'($signed(a.z)) - longint'($signed(b.z));
        sum = dx * dx + dy * dy + dz * dz;
        return (sum > longint'(SQ_MAX)) ? SQ_MAX : SQ_W'(sum);
    endfunction

    // Runs one candidate through the filter and returns the result beat it
    // should produce. The store and the closest pair advance as a side effect.
    function automatic t_verdict filter_candidate(t_cand c);
        t_verdict        v;
        bit              too_close;
        logic [SQ_W-1:0] d;
        v         = '0;
        too_close = 1'b0;
        if (c.clr) begin
            kept_count = 0;
            best_sq    = SQ_MAX;
            best_lo    = 0;
            best_hi    = 0;
        end
        if (kept_count >= MAX_POINTS) begin
            // A full store rejects without any distance test.
            v.store_full = 1'b1;
        end else begin
            for (int i = 0; i < kept_count && !too_close; i++) begin
                too_close = sq_distance(c.pt, kept_pts[i]) < spacing_sq;
            end
            if (!too_close) begin
                // Strict compare in ascending index order keeps the oldest pair.
                for (int i = 0; i < kept_count; i++) begin
                    d = sq_distance(kept_pts[i], c.pt);
                    if (d < best_sq) begin
                        best_sq = d;
                        best_lo = i;
                        best_hi = kept_count;
                    end
                end
                v.accepted    = 1'b1;
                v.point_index = IDX_W'(kept_count);
                kept_pts[kept_count] = c.pt;
                kept_count++;
            end
        end
        v.point_count = CNT_W'(kept_count);
        v.closest_sq  = best_sq;
        v.pair_first  = IDX_W'(best_lo);
        v.pair_second = IDX_W'(best_hi);
        return v;
    endfunction

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Candidate side. A beat that is offered stays put until it is taken; the
    // prediction is made at the edge where it is taken, so the threshold and
    // store seen are the ones the block sees.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            tx_want = filter_candidate(on_wire);
            expected_verdicts.insert(expected_verdicts.size(),
                                     on_wire.known ? on_wire.verdict : tx_want);
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && cand_q.size() != 0 && $urandom_range(99) < gap_pct) begin
                // Idle burst that starts with this one; send_gap holds the rest of it.
                send_gap = $urandom_range(6);
                s_axis_tvalid <= 1'b0;
            end else if (cand_q.size() != 0) begin
                on_wire = cand_q.pop_front();
                s_axis_tdata  <= {on_wire.pt.z, on_wire.pt.y, on_wire.pt.x};
                s_axis_tuser  <= on_wire.clr;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side. Every beat taken is compared field by field with the
    // oldest expectation. Ready drops in short random bursts, and once in a
    // long hold-off that lets the output register fill and backs up the input.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_got.accepted    = m_axis_tdata[ACC_LO];
            rx_got.store_full  = m_axis_tdata[FULL_LO];
            rx_got.point_index = m_axis_tdata[IDX_LO +: IDX_W];
            rx_got.point_count = m_axis_tdata[CNT_LO +: CNT_W];
            rx_got.closest_sq  = m_axis_tdata[SQ_LO +: SQ_W];
            rx_got.pair_first  = m_axis_tdata[FIRST_LO +: IDX_W];
            rx_got.pair_second = m_axis_tdata[SECOND_LO +: IDX_W];
            if (expected_verdicts.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                rx_want = expected_verdicts.pop_front();
                check_field("accepted", rx_want.accepted, rx_got.accepted);
                check_field("store_full", rx_want.store_full, rx_got.store_full);
                check_field("point_index", rx_want.point_index, rx_got.point_index);
                check_field("point_count", rx_want.point_count, rx_got.point_count);
                check_field("closest_sq", rx_want.closest_sq, rx_got.closest_sq);
                check_field("pair_first", rx_want.pair_first, rx_got.pair_first);
                check_field("pair_second", rx_want.pair_second, rx_got.pair_second);
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Waits until nothing is queued, offered or outstanding. Polled on the
    // falling edge so that all updates of the rising edge have settled.
    task automatic wait_all_settled();
        do @(negedge i_clk);
        while (cand_q.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0);
    endtask

    // One APB transfer: a setup cycle, then an access cycle that completes at
    // the rising edge where pready is high. Read data is sampled mid-access.
    task automatic apb_access(bit is_write, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= THRESH_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk);
        while (!pready);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The threshold only changes once the block has answered everything.
    task automatic set_threshold(logic [SQ_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        wait_all_settled();
        apb_access(1'b1, APB_DATA_W'(value), readback);
        spacing_sq = value;
        apb_access(1'b0, '0, readback);
        check_field("min_dist_sq readback", value, readback);
    endtask

    task automatic push_cand(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                             logic signed [COORD_BITS-1:0] z, logic clr);
        t_cand c;
        c       = '0;
        c.pt    = '{x, y, z};
        c.clr   = clr;
        cand_q.insert(cand_q.size(), c);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(t_spot_mode mode, longint center,
                                                               int spread);
        longint v;
        case (mode)
            CLUSTER: begin
                v = center + longint'($urandom_range(2 * spread)) - spread;
                if (v < COORD_MIN) v = COORD_MIN;
                if (v > COORD_MAX) v = COORD_MAX;
                return COORD_BITS'(v);
            end
            EDGES: begin
                case ($urandom_range(3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // A run is a cleared store followed by points of one flavor: mostly a
    // cluster, whose spread decides how many fall inside the threshold, now
    // and then the range ends, zero and minus one, or points anywhere. A stray
    // clear inside a run breaks the sequence now and then.
    task automatic push_run(int run_len);
        t_spot_mode mode;
        longint     cx;
        longint     cy;
        longint     cz;
        int         spread;
        int         pick;
        pick = $urandom_range(99);
        mode = (pick < 70) ? CLUSTER : (pick < 85) ? EDGES : ANYWHERE;
        case ($urandom_range(3))
            0:       spread = 3;
            1:       spread = 40;
            2:       spread = 600;
            default: spread = 5000;
        endcase
        cx = pick_coord(ANYWHERE, 0, 0);
        cy = pick_coord(ANYWHERE, 0, 0);
        cz = pick_coord(ANYWHERE, 0, 0);
        for (int k = 0; k < run_len; k++) begin
            push_cand(pick_coord(mode, cx, spread), pick_coord(mode, cy, spread),
                      pick_coord(mode, cz, spread), k == 0 || $urandom_range(39) == 0);
        end
    endtask

    initial begin
        logic [APB_DATA_W-1:0] readback;
        logic [SQ_W-1:0]       thresh;
        int                    sent;
        int                    run_len;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The register must come out of reset with its documented value.
        apb_access(1'b0, '0, readback);
        check_field("min_dist_sq after reset", MIN_DIST_SQ_RESET, readback);

        for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
            if (DIRECTED_ROWS[r].cfg_write) begin
                set_threshold(DIRECTED_ROWS[r].cfg_value);
            end
            cand_q.insert(cand_q.size(), DIRECTED_ROWS[r].cand);
        end

        // Random phases, each under its own threshold. The last phase runs
        // without any idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       thresh = MIN_DIST_SQ_RESET;
                1:       thresh = SQ_W'($urandom_range(5000));
                2:       thresh = SQ_W'(1);
                3:       thresh = SQ_W'({$urandom_range(3), $urandom}) >> $urandom_range(33);
                4:       thresh = SQ_MAX;
                default: thresh = '0;
            endcase
            set_threshold(thresh);
            calm      = (ph == RANDOM_PHASES - 1);
            gap_pct   = $urandom_range(5, 30);
            stall_pct = $urandom_range(5, 30);
            sent      = 0;
            while (sent < PHASE_ITEMS) begin
                run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(2, 24);
                push_run(run_len);
                if (ph == 2 && sent == 0) begin
                    // Long hold-off while the candidate side keeps offering.
                    hold_request = 1'b1;
                end
                if (ph == 3 && sent == 0) begin
                    // The candidate side pauses until all results are back.
                    wait_all_settled();
                end
                sent += run_len;
            end
        end

        wait_all_settled();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mdpf_pkg.sv
rtl/mdpf_ctrl.sv
rtl/mdpf_datapath.sv
rtl/min_distance_point_filter.sv
tb/sv/min_distance_point_filter_tb.sv
